// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the sort engine.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on the rising clock, off while reset is held.
`define ISE_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("sort engine assertion failed");

// Two conditions that must never be true in the same cycle.
`define ISE_NEVER_BOTH(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !((a) && (b))) \
		else $error("sort engine exclusion violated");

`endif

// ----- hw/rtl/ise_pkg.sv -----
// Shared constants and types of the integer sort engine.
// Depends on nothing.
`timescale 1ns / 1ps

package ise_pkg;
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} ise_wr_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
		logic             dropped;
	} ise_ctl_t;
endpackage

// ----- hw/rtl/ise_if.sv -----
// Valid/ready channel interfaces of the integer sort engine.
// Depends on nothing.
`timescale 1ns / 1ps

interface ise_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] element;
	logic               final_element;
	modport source (output valid, element, final_element, input ready);
	modport sink (input valid, element, final_element, output ready);
endinterface

interface ise_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sorted_value;
	logic               end_of_run;
	logic               dropped_flag;
	modport source (output valid, sorted_value, end_of_run, dropped_flag, input ready);
	modport sink (input valid, sorted_value, end_of_run, dropped_flag, output ready);
endinterface

// ----- hw/rtl/ise_rank_unit.sv -----
// Element store and rank counter: loads a run, then computes each element's
// output position and writes it to the result buffer. Depends on ise_pkg and ise_if.
`timescale 1ns / 1ps

module ise_rank_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	ise_in_if.sink                 elements,
	output ise_pkg::ise_wr_t       wr,
	output ise_pkg::ise_ctl_t      ctl,
	input  logic                   done
);
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RDI  = 3'd1;
	localparam logic [2:0] ST_LATI = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_WAIT = 3'd6;

	logic [2:0]                       state_q;
	logic [ise_pkg::CNT_W-1:0]        cnt_q, i_q, j_q, rank_q, j_s1;
	logic                             ovf_q, vld_s1;
	logic [ise_pkg::DATA_W-1:0]       vi_q, rdata_q;
	logic [ise_pkg::ADDR_W-1:0]       raddr;
	logic [ise_pkg::DATA_W-1:0]       mem [ise_pkg::CAPACITY];
	logic                             accept, store, less;

	assign elements.ready = (state_q == ST_LOAD);
	assign accept = elements.valid && elements.ready;
	assign store  = (cnt_q < ise_pkg::CNT_W'(ise_pkg::CAPACITY));
	assign raddr  = (state_q == ST_RDI) ? i_q[ise_pkg::ADDR_W-1:0]
	                                    : j_q[ise_pkg::ADDR_W-1:0];
	// Equal values keep arrival order, so every rank is distinct.
	assign less = ($signed(rdata_q) < $signed(vi_q)) ||
	              ((rdata_q == vi_q) && (j_s1 < i_q));

	assign wr.we   = (state_q == ST_WR);
	assign wr.addr = rank_q[ise_pkg::ADDR_W-1:0];
	assign wr.data = vi_q;
	assign ctl.start   = (state_q == ST_EMIT);
	assign ctl.count   = cnt_q;
	assign ctl.dropped = ovf_q;

	always_ff @(posedge clk) begin
		if (accept && store) begin
			mem[cnt_q[ise_pkg::ADDR_W-1:0]] <= elements.element;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			rank_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (elements.final_element) begin
							i_q     <= '0;
							state_q <= ST_RDI;
						end
					end
				end
				ST_RDI: begin
					rank_q  <= '0;
					state_q <= ST_LATI;
				end
				ST_LATI: begin
					vi_q    <= rdata_q;
					j_q     <= '0;
					vld_s1  <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q < cnt_q) begin
						j_q    <= j_q + 1'b1;
						j_s1   <= j_q;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && less) begin
						rank_q <= rank_q + 1'b1;
					end
					if ((j_q == cnt_q) && !vld_s1) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					i_q <= i_q + 1'b1;
					if (i_q == cnt_q - 1'b1) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_RDI;
					end
				end
				ST_EMIT: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (done) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- hw/rtl/ise_out_buffer.sv -----
// Result buffer: holds elements at their ranks and streams them out in order.
// Depends on ise_pkg and ise_if.
`timescale 1ns / 1ps

module ise_out_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  ise_pkg::ise_wr_t  wr,
	input  ise_pkg::ise_ctl_t ctl,
	output logic              done,
	ise_out_if.source         results
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_SHOW = 2'd2;

	logic [1:0]                 state_q;
	logic [ise_pkg::CNT_W-1:0]  n_q, k_q;
	logic                       drop_q, last, accept;
	logic [ise_pkg::DATA_W-1:0] rdata_q;
	logic [ise_pkg::DATA_W-1:0] mem [ise_pkg::CAPACITY];

	assign last   = (k_q == n_q - 1'b1);
	assign accept = results.valid && results.ready;
	assign done   = accept && last;

	assign results.valid        = (state_q == ST_SHOW);
	assign results.sorted_value = rdata_q;
	assign results.end_of_run   = last;
	assign results.dropped_flag = drop_q && (k_q == '0);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		// The read register only moves in the read state, so a stalled result holds.
		if (state_q == ST_RD) begin
			rdata_q <= mem[k_q[ise_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			k_q     <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						n_q     <= ctl.count;
						drop_q  <= ctl.dropped;
						k_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (accept) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/integer_sort_engine.sv -----
// Integer sort engine top level: rank unit plus result buffer.
// Depends on ise_pkg, ise_if, ise_rank_unit and ise_out_buffer.
//
// Usage: elements arrive on the "elements" channel, one signed 32-bit value per
// transaction, the last of a run marked by final_element. Up to 64 are stored;
// later ones are discarded and the first result of the run sets dropped_flag.
// After the final transaction the block sorts, then gives every stored value in
// ascending signed order on "results", end_of_run marking the largest.
// The elements channel stays ready while loading. Sorting counts each element's
// rank by a scan of the element memory through its single read port. On output,
// each result is read from the result memory and then presented.
// The elements channel is not ready from the final transaction until the last
// result is taken. A stalled receiver simply holds the current result.
// Reset empties the run at once; no clearing pass is needed.
`timescale 1ns / 1ps

module integer_sort_engine (
	input  logic      clk,
	input  logic      arst_n,
	ise_in_if.sink    elements,
	ise_out_if.source results
);
	ise_pkg::ise_wr_t  wr;
	ise_pkg::ise_ctl_t ctl;
	logic              done;

	ise_rank_unit u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.elements (elements),
		.wr       (wr),
		.ctl      (ctl),
		.done     (done)
	);

	ise_out_buffer u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.ctl     (ctl),
		.done    (done),
		.results (results)
	);
endmodule

// ----- hw/rtl/ise_checker.sv -----
// Port-level checker of the integer sort engine, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ise_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sorted_value,
	input logic        end_of_run
);
	`ISE_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(sorted_value)))
	`ISE_NEVER_BOTH(a_no_overlap, clk, arst_n, in_ready, out_valid)
	`ISE_ASSERT(a_mid_run_busy, clk, arst_n, (out_valid && out_ready && !end_of_run) |=> !in_ready)
	`ISE_ASSERT(a_final_blocks, clk, arst_n, (out_valid && out_ready) |=> !out_valid)
endmodule

bind integer_sort_engine ise_checker u_ise_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (elements.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.sorted_value (results.sorted_value),
	.end_of_run   (results.end_of_run)
);

// ----- verif/tb.sv -----
// Self-checking testbench of the integer sort engine: directed and random
// runs of signed elements, sorted by a local predictor and compared with the
// results. Depends on ise_pkg, ise_if and the integer_sort_engine RTL.
`timescale 1ns / 1ps

module tb;
	typedef struct {
		logic signed [31:0] element;
		logic               final_element;
	} elem_t;

	typedef struct {
		logic signed [31:0] sorted_value;
		logic               end_of_run;
		logic               dropped_flag;
	} sorted_t;

	logic clk;
	logic arst_n;

	ise_in_if  elements ();
	ise_out_if results ();

	integer_sort_engine u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.elements(elements.sink),
		.results (results.source)
	);

	elem_t              pending_q[$];
	sorted_t            sorted_q[$];
	logic signed [31:0] run_store[$];
	bit                 run_dropped;
	int                 mismatches;
	int                 idle_cycles;
	bit                 timed_out;
	int                 tx_wait;
	int                 rx_wait;
	int                 hold_off;
	int                 hold_request;
	bit                 pause_tx;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Predictor: accumulate the run and, on its final element, sort it.
	task automatic predict_sort(input elem_t e);
		logic signed [31:0] v;
		int j;
		begin
			if (run_store.size() < ise_pkg::CAPACITY)
				run_store.insert(run_store.size(), e.element);
			else
				run_dropped = 1'b1;
			if (e.final_element) begin
				for (int i = 1; i < run_store.size(); i++) begin
					v = run_store[i];
					j = i;
					while (j > 0 && run_store[j-1] > v) begin
						run_store[j] = run_store[j-1];
						j--;
					end
					run_store[j] = v;
				end
				for (int i = 0; i < run_store.size(); i++)
					sorted_q.insert(sorted_q.size(), sorted_t'{run_store[i],
						i == run_store.size() - 1, i == 0 && run_dropped});
				run_store.delete();
				run_dropped = 1'b0;
			end
		end
	endtask

	// Driver: each offered transaction carries its own gap after acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elements.valid         <= 1'b0;
			elements.element       <= '0;
			elements.final_element <= 1'b0;
			tx_wait                <= 0;
		end else begin
			if (elements.valid && elements.ready) begin
				predict_sort(elem_t'{elements.element, elements.final_element});
			end
			if (elements.valid && !elements.ready) begin
				// hold the offered transaction
			end else if (tx_wait > 0) begin
				elements.valid <= 1'b0;
				tx_wait        <= tx_wait - 1;
			end else if (pending_q.size() > 0 && !pause_tx) begin
				elements.valid         <= 1'b1;
				elements.element       <= pending_q[0].element;
				elements.final_element <= pending_q[0].final_element;
				tx_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
				void'(pending_q.pop_front());
			end else begin
				elements.valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			rx_wait        = 0;
			hold_off      <= 0;
		end else begin
			if (results.valid && results.ready) begin
				if (sorted_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d", results.sorted_value);
				end else begin
					if (results.sorted_value !== sorted_q[0].sorted_value ||
							results.end_of_run !== sorted_q[0].end_of_run ||
							results.dropped_flag !== sorted_q[0].dropped_flag) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
								sorted_q[0].sorted_value, sorted_q[0].end_of_run,
								sorted_q[0].dropped_flag, results.sorted_value,
								results.end_of_run, results.dropped_flag);
					end
					void'(sorted_q.pop_front());
				end
			end
			if (hold_request > 0 && hold_off == 0) begin
				hold_off      <= hold_request;
				hold_request  <= 0;
				results.ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off      <= hold_off - 1;
				results.ready <= 1'b0;
			end else if (results.valid && results.ready) begin
				rx_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
				results.ready <= (rx_wait == 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
				results.ready <= (rx_wait == 0);
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (elements.valid && elements.ready) ||
				(results.valid && results.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 60000 && !timed_out) begin
			timed_out = 1'b1;
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic queue_run(input int len, input int mode);
		elem_t e;
		begin
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: e.element = $urandom();
					1: e.element = $signed($urandom_range(0, 6)) - 3;
					default: e.element = ($urandom_range(0, 1)) ? 32'sh7fffffff :
						32'sh80000000;
				endcase
				e.final_element = (i == len - 1);
				pending_q.insert(pending_q.size(), e);
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() > 0 || elements.valid || sorted_q.size() > 0 ||
				run_store.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int total;
		arst_n = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		hold_request = 0;
		pause_tx = 1'b0;
		run_dropped = 1'b0;
		results.ready = 1'b0;
		elements.valid = 1'b0;
		elements.element = '0;
		elements.final_element = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single element, both extremes, duplicates, full store.
		pending_q.insert(pending_q.size(), elem_t'{32'sh80000000, 1'b1});
		pending_q.insert(pending_q.size(), elem_t'{32'sh7fffffff, 1'b1});
		queue_run(2, 2);
		queue_run(6, 1);
		queue_run(4, 0);
		wait_drained();
		queue_run(ise_pkg::CAPACITY, 0);
		wait_drained();
		// Overflow, the final element itself discarded, then a run that is
		// offered while the receiver holds off on the first one's results.
		queue_run(ise_pkg::CAPACITY + 3, 1);
		queue_run(5, 0);
		wait (results.valid);
		hold_request = 400;
		wait_drained();

		total = 0;
		while (total < 320) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) :
				$urandom_range(1, 8);
			queue_run(len, $urandom_range(0, 3) == 0 ? 1 : 0);
			total += len;
			if ($urandom_range(0, 15) == 0) begin
				wait_drained();
				pause_tx = 1'b1;
				repeat (20) @(posedge clk);
				pause_tx = 1'b0;
			end
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
